>>> hdl/khcv_pkg.sv
package khcv_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] KEY_RESET = 32'h6a09e667;

  localparam logic [7:0] CHANNEL_RESET = 8'd129;
  localparam logic [7:0] VERSION_RESET = 8'd1;
  localparam logic [7:0] COMMAND_RESET = 8'd1;

  localparam logic [3:0] MAC_FIRST_POS = 4'd8;
  localparam logic [3:0] LAST_POS      = 4'd11;
  localparam logic [3:0] COUNT_SAT     = 4'd13;

  localparam int unsigned KEY_BYTES = 4;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_LEN = 2'd1,
    ST_HDR = 2'd2,
    ST_MAC = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_KEY     = 2'd0,
    REG_VERSION = 2'd1,
    REG_COMMAND = 2'd2
  } reg_idx_e;

  function automatic logic [31:0] fnv_mix(logic [31:0] h, logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FNV_PRIME;
  endfunction

  function automatic logic [31:0] keyed_seed(logic [31:0] key);
    logic [31:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < KEY_BYTES; i++) begin
      h = fnv_mix(h, key[8*i +: 8]);
    end
    return h;
  endfunction

  localparam logic [31:0] SEED_RESET = keyed_seed(KEY_RESET);

  typedef struct packed {
    logic        busy;
    logic [31:0] seed;
    logic [7:0]  expected_version;
    logic [7:0]  hop_command;
  } cfg_state_t;

  typedef struct packed {
    status_e     pre_status;
    logic [31:0] mac;
    logic [31:0] hash;
    logic [7:0]  channel;
  } entry_t;

endpackage

>>> hdl/khcv_if.sv
interface khcv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source(output valid, frame_byte, last_byte, input ready);
  modport sink(input valid, frame_byte, last_byte, output ready);
endinterface

interface khcv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] channel;
  logic       channel_changed;

  modport source(output valid, status, channel, channel_changed, input ready);
  modport sink(input valid, status, channel, channel_changed, output ready);
endinterface

interface khcv_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> hdl/khcv_fifo.sv
module khcv_fifo #(
  parameter int Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  khcv_pkg::entry_t  wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output khcv_pkg::entry_t  rdata_o,
  output logic              valid_o
);
  import khcv_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   count_q;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("Queue written while full.");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("Queue read while empty.");

endmodule

>>> hdl/khcv_cfg.sv
module khcv_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  khcv_cfg_if.sink              cfg_i,
  output khcv_pkg::cfg_state_t  state_o
);
  import khcv_pkg::*;

  logic        cfg_xfer;
  logic [31:0] key_shift_q;
  logic [31:0] seed_q;
  logic [7:0]  version_q;
  logic [7:0]  command_q;
  logic        busy_q;
  logic [1:0]  step_q;

  assign cfg_i.ready = !busy_q;
  assign cfg_xfer    = cfg_i.valid && cfg_i.ready;

  assign state_o.busy             = busy_q;
  assign state_o.seed             = seed_q;
  assign state_o.expected_version = version_q;
  assign state_o.hop_command      = command_q;

  // A key write restarts the seed computation, one key byte per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_shift_q <= KEY_RESET;
      seed_q      <= SEED_RESET;
      version_q   <= VERSION_RESET;
      command_q   <= COMMAND_RESET;
      busy_q      <= 1'b0;
      step_q      <= '0;
    end else if (cfg_xfer) begin
      case (reg_idx_e'(cfg_i.index))
        REG_KEY: begin
          key_shift_q <= cfg_i.data;
          seed_q      <= FNV_BASIS;
          busy_q      <= 1'b1;
          step_q      <= '0;
        end
        REG_VERSION: version_q <= cfg_i.data[7:0];
        REG_COMMAND: command_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end else if (busy_q) begin
      seed_q      <= fnv_mix(seed_q, key_shift_q[7:0]);
      key_shift_q <= key_shift_q >> 8;
      step_q      <= step_q + 2'd1;
      if (step_q == 2'(KEY_BYTES - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  a_key_starts_seed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_xfer && (cfg_i.index == REG_KEY) |=> busy_q && (seed_q == FNV_BASIS))
    else $error("Key write did not restart the seed computation.");

endmodule

>>> hdl/khcv_front.sv
module khcv_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  khcv_in_if.sink               in_i,
  input  khcv_pkg::cfg_state_t  cfg_i,
  input  logic                  full_i,
  output logic                  push_o,
  output khcv_pkg::entry_t      entry_o
);
  import khcv_pkg::*;

  logic [3:0]  count_q;
  logic [31:0] hash_q;
  logic [7:0]  version_q;
  logic [7:0]  command_q;
  logic [7:0]  channel_q;
  logic [31:0] mac_q;

  logic        in_xfer;
  logic        in_mac;
  logic [31:0] base;
  logic [7:0]  mix_byte;
  logic [31:0] hash_d;
  logic [3:0]  count_d;

  assign in_i.ready = !cfg_i.busy && !full_i;
  assign in_xfer    = in_i.valid && in_i.ready;

  assign in_mac   = (count_q >= MAC_FIRST_POS) && (count_q <= LAST_POS);
  assign base     = (count_q == '0) ? cfg_i.seed : hash_q;
  assign mix_byte = in_mac ? 8'd0 : in_i.frame_byte;
  assign hash_d   = fnv_mix(base, mix_byte);

  always_comb begin
    if (in_i.last_byte) begin
      count_d = '0;
    end else if (count_q < COUNT_SAT) begin
      count_d = count_q + 4'd1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_xfer) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      hash_q <= hash_d;
      if (count_q == 4'd0) begin
        version_q <= in_i.frame_byte;
      end
      if (count_q == 4'd1) begin
        command_q <= in_i.frame_byte;
      end
      if (count_q == 4'd2) begin
        channel_q <= in_i.frame_byte;
      end
      if (in_mac) begin
        mac_q[{count_q[1:0], 3'b000} +: 8] <= in_i.frame_byte;
      end
    end
  end

  assign push_o = in_xfer && in_i.last_byte;

  always_comb begin
    if (count_q != LAST_POS) begin
      entry_o.pre_status = ST_LEN;
    end else if ((version_q != cfg_i.expected_version) ||
                 (command_q != cfg_i.hop_command)) begin
      entry_o.pre_status = ST_HDR;
    end else begin
      entry_o.pre_status = ST_OK;
    end
    entry_o.mac     = {in_i.frame_byte, mac_q[23:0]};
    entry_o.hash    = hash_d;
    entry_o.channel = channel_q;
  end

endmodule

>>> hdl/khcv_back.sv
module khcv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  khcv_pkg::entry_t  entry_i,
  input  logic              valid_i,
  output logic              pop_o,
  khcv_out_if.source        out_o
);
  import khcv_pkg::*;

  logic       out_valid_q;
  status_e    status_q;
  logic [7:0] channel_q;
  logic       changed_q;
  logic [7:0] active_q;

  logic       mac_ok;
  logic       frame_ok;
  status_e    status_d;

  assign pop_o = valid_i && (!out_valid_q || out_o.ready);

  assign mac_ok   = (entry_i.mac == entry_i.hash);
  assign frame_ok = (entry_i.pre_status == ST_OK) && mac_ok;

  always_comb begin
    if (entry_i.pre_status != ST_OK) begin
      status_d = entry_i.pre_status;
    end else if (mac_ok) begin
      status_d = ST_OK;
    end else begin
      status_d = ST_MAC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      active_q    <= CHANNEL_RESET;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
      if (frame_ok) begin
        active_q <= entry_i.channel;
      end
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q  <= status_d;
      channel_q <= frame_ok ? entry_i.channel : active_q;
      changed_q <= frame_ok && (entry_i.channel != active_q);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = status_q;
  assign out_o.channel         = channel_q;
  assign out_o.channel_changed = changed_q;

  a_reject_keeps_channel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != ST_OK) |-> !out_o.channel_changed)
    else $error("Rejected frame reported a channel change.");

  a_shown_channel_is_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.channel == active_q))
    else $error("Reported channel differs from the active channel.");

endmodule

>>> hdl/keyed_hop_command_verifier.sv
// Channel  Direction  Payload
// in_i     sink       frame_byte[7:0], last_byte
// out_o    source     status[1:0], channel[7:0], channel_changed
// cfg_i    sink       index[1:0], data[31:0]
//
// One byte is taken per cycle unless stalled; a result is queued, then registered at out_o.
// A key write occupies the seed unit; input and configuration stall until the seed is ready.
// Reset is asynchronous and active low; the seed of the reset key is ready at once.
// Apart from a key write, the front stalls only when the result queue is full.
// The output register frees on each transfer.
module keyed_hop_command_verifier #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  khcv_in_if.sink     in_i,
  khcv_out_if.source  out_o,
  khcv_cfg_if.sink    cfg_i
);
  import khcv_pkg::*;

  cfg_state_t cfg_state;
  entry_t     push_entry;
  entry_t     head_entry;
  logic       push;
  logic       pop;
  logic       full;
  logic       head_valid;

  khcv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .state_o (cfg_state)
  );

  khcv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg_state),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  khcv_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .valid_o (head_valid)
  );

  khcv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .valid_i (head_valid),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
